// ===== src/fctg_pkg.sv =====
`default_nettype none
package fctg_pkg;

	localparam int VOICES_DEF      = 4;
	localparam int NOTE_FRAMES_DEF = 60;

	localparam int PHASE_W = 24;
	localparam int FREQ_W  = 15;
	localparam int GAIN_W  = 8;
	localparam int SMP_W   = 16;

	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_PLAY   = 2'd1;
	localparam logic [1:0] OP_STOP   = 2'd2;
	localparam logic [1:0] OP_FRAME  = 2'd3;

	localparam logic [1:0] WAVE_SQUARE   = 2'd0;
	localparam logic [1:0] WAVE_SINE     = 2'd1;
	localparam logic [1:0] WAVE_TRIANGLE = 2'd2;
	localparam logic [1:0] WAVE_NOISE    = 2'd3;

	// 2^24 / 48000 per Hz, scaled by 64
	localparam logic [14:0] STEP_MUL   = 15'd22370;
	localparam logic [15:0] LFSR_TAPS  = 16'hB400;
	localparam logic [15:0] LFSR_SEED  = 16'hACE1;

	localparam logic [14:0] SINE_TABLE [64] = '{
		15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,  15'd5602,
		15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278, 15'd11039, 15'd11793,
		15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446, 15'd16151, 15'd16846, 15'd17530,
		15'd18204, 15'd18868, 15'd19519, 15'd20159, 15'd20787, 15'd21403, 15'd22005, 15'd22594,
		15'd23170, 15'd23731, 15'd24279, 15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790,
		15'd27245, 15'd27683, 15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956,
		15'd30273, 15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
		15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728, 15'd32757
	};

	// one Galois step: shift right, fold the taps in when a one falls out
	function automatic logic [15:0] lfsr_step(input logic [15:0] s);
		logic [15:0] n;
		n = {1'b0, s[15:1]};
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== src/fctg_cmd_if.sv =====
`default_nettype none
interface fctg_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [1:0]  channel;
	logic [14:0] frequency_hz;
	logic [7:0]  volume;
	logic [1:0]  wave_kind;

	modport source (output valid, operation, channel, frequency_hz, volume, wave_kind,
		input ready);
	modport sink (input valid, operation, channel, frequency_hz, volume, wave_kind,
		output ready);
endinterface
`default_nettype wire

// ===== src/fctg_mix_if.sv =====
`default_nettype none
interface fctg_mix_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;

	modport source (output valid, sample, input ready);
	modport sink (input valid, sample, output ready);
endinterface
`default_nettype wire

// ===== src/fctg_wave.sv =====
`default_nettype none
module fctg_wave (
	input  wire logic [fctg_pkg::PHASE_W-1:0] phase,
	input  wire logic [1:0]                   wave_kind,
	input  wire logic [15:0]                  noise,
	output logic signed [fctg_pkg::SMP_W-1:0] value
);

	logic [1:0]         quad;
	logic [5:0]         idx;
	logic [6:0]         tidx;
	logic [14:0]        mag;
	logic signed [17:0] tri_hi;

	always_comb begin
		quad = phase[23:22];
		idx  = phase[21:16];
		tidx = quad[0] ? (7'd64 - {1'b0, idx}) : {1'b0, idx};
		mag  = tidx[6] ? 15'd32767 : fctg_pkg::SINE_TABLE[tidx[5:0]];
		tri_hi = 18'sd98304 - $signed({1'b0, phase[23:7]});

		unique case (wave_kind)
			fctg_pkg::WAVE_SQUARE: begin
				value = phase[23] ? -16'sd32768 : 16'sd32767;
			end
			fctg_pkg::WAVE_SINE: begin
				value = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			end
			fctg_pkg::WAVE_TRIANGLE: begin
				if (!phase[23]) begin
					// (p >> 7) - 32768 is the top bit flipped
					value = $signed({~phase[22], phase[21:7]});
				end else if (tri_hi > 18'sd32767) begin
					value = 16'sd32767;
				end else begin
					value = tri_hi[15:0];
				end
			end
			default: begin
				value = $signed(noise);
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/four_channel_tone_generator.sv =====
// Tone generator with VOICES voices mixed into one signed 16-bit sample.
// cmd carries one item per handshake: operation, channel, frequency_hz,
// volume, wave_kind. A sample tick yields one item on mix; play, stop and
// frame tick yield none and only update the voice registers.
// An accepted item is held in the input register; a sample tick's result
// is then registered into the output register that drives mix. One item
// per cycle is taken sustained while mix does not stall: wave lookup, gain
// multiply per voice, the mix adder tree and the noise register chain all
// sit in the single stage between the input and output registers.
// Reset (arst_n low) silences every voice, clears phases and steps, and
// loads the noise register with its seed. No memories, no clearing pass.
// When mix stalls, the pending sample is held; a sample tick waiting in the
// input register holds too and cmd.ready drops, while play, stop and frame
// items keep flowing since they produce nothing for mix.
`default_nettype none
module four_channel_tone_generator #(
	parameter int VOICES      = fctg_pkg::VOICES_DEF,
	parameter int NOTE_FRAMES = fctg_pkg::NOTE_FRAMES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	fctg_cmd_if.sink   cmd,
	fctg_mix_if.source mix
);

	localparam int FW = $clog2(NOTE_FRAMES + 1);
	localparam int SW = 17 + $clog2(VOICES);
	localparam int PW = fctg_pkg::PHASE_W;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [1:0]  chan_s1;
	logic [14:0] freq_s1;
	logic [7:0]  vol_s1;
	logic [1:0]  wave_s1;

	logic [PW-1:0] phase_q  [VOICES];
	logic [PW-1:0] step_q   [VOICES];
	logic [7:0]    gain_q   [VOICES];
	logic [1:0]    kind_q   [VOICES];
	logic [FW-1:0] frames_q [VOICES];
	logic [15:0]   noise_q;

	logic                     mix_valid_q;
	logic signed [15:0]       mix_sample_q;

	logic                     adv;
	logic [VOICES-1:0]        active;
	logic [15:0]              noise_c   [VOICES+1];
	logic signed [15:0]       wave_v    [VOICES];
	logic signed [16:0]       contrib   [VOICES];
	logic signed [SW-1:0]     total;
	logic signed [SW-1:0]     quarter;
	logic signed [15:0]       sat;
	logic [29:0]              step_prod;

	assign adv = valid_s1 && (op_s1 != fctg_pkg::OP_SAMPLE || !mix_valid_q || mix.ready);
	assign cmd.ready  = !valid_s1 || adv;
	assign mix.valid  = mix_valid_q;
	assign mix.sample = mix_sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1   <= cmd.operation;
			chan_s1 <= cmd.channel;
			freq_s1 <= cmd.frequency_hz;
			vol_s1  <= cmd.volume;
			wave_s1 <= cmd.wave_kind;
		end
	end

	// noise voices step the shared register in voice order
	always_comb begin
		noise_c[0] = noise_q;
		for (int v = 0; v < VOICES; v++) begin
			active[v] = (frames_q[v] != '0) && (gain_q[v] != '0);
			if (active[v] && kind_q[v] == fctg_pkg::WAVE_NOISE) begin
				noise_c[v+1] = fctg_pkg::lfsr_step(noise_c[v]);
			end else begin
				noise_c[v+1] = noise_c[v];
			end
		end
	end

	for (genvar g = 0; g < VOICES; g++) begin : g_voice
		logic signed [24:0] prod;

		fctg_wave u_wave (
			.phase     (phase_q[g]),
			.wave_kind (kind_q[g]),
			.noise     (noise_c[g+1]),
			.value     (wave_v[g])
		);

		// floor(prod / 256) is the upper bits
		assign prod       = 25'(wave_v[g]) * 25'($signed({1'b0, gain_q[g]}));
		assign contrib[g] = active[g] ? prod[24:8] : 17'sd0;
	end

	always_comb begin
		total = '0;
		for (int v = 0; v < VOICES; v++) begin
			total = total + SW'(contrib[v]);
		end
		quarter = total >>> 2;
		if (quarter > SW'(32767)) begin
			sat = 16'sd32767;
		end else if (quarter < -SW'(32768)) begin
			sat = -16'sd32768;
		end else begin
			sat = quarter[15:0];
		end
	end

	assign step_prod = 30'(freq_s1) * 30'(fctg_pkg::STEP_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				phase_q[v]  <= '0;
				step_q[v]   <= '0;
				gain_q[v]   <= '0;
				kind_q[v]   <= '0;
				frames_q[v] <= '0;
			end
			noise_q <= fctg_pkg::LFSR_SEED;
		end else if (adv) begin
			unique case (op_s1)
				fctg_pkg::OP_SAMPLE: begin
					for (int v = 0; v < VOICES; v++) begin
						if (active[v]) begin
							phase_q[v] <= phase_q[v] + step_q[v];
						end
					end
					noise_q <= noise_c[VOICES];
				end
				fctg_pkg::OP_PLAY: begin
					for (int v = 0; v < VOICES; v++) begin
						if (int'(chan_s1) == v) begin
							phase_q[v]  <= '0;
							step_q[v]   <= step_prod[29:6];
							gain_q[v]   <= vol_s1;
							kind_q[v]   <= wave_s1;
							frames_q[v] <= FW'(NOTE_FRAMES);
						end
					end
				end
				fctg_pkg::OP_STOP: begin
					for (int v = 0; v < VOICES; v++) begin
						if (int'(chan_s1) == v) begin
							gain_q[v]   <= '0;
							frames_q[v] <= '0;
						end
					end
				end
				default: begin
					for (int v = 0; v < VOICES; v++) begin
						if (frames_q[v] != '0) begin
							frames_q[v] <= frames_q[v] - FW'(1);
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_valid_q <= 1'b0;
		end else if (adv && op_s1 == fctg_pkg::OP_SAMPLE) begin
			mix_valid_q <= 1'b1;
		end else if (mix.ready) begin
			mix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && op_s1 == fctg_pkg::OP_SAMPLE) begin
			mix_sample_q <= sat;
		end
	end

	a_tick_gives_sample: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == fctg_pkg::OP_SAMPLE |=> mix.valid)
		else $error("sample tick did not produce a mix item");

	a_no_spurious_sample: assert property (@(posedge clk) disable iff (!arst_n)
		!mix.valid && !(adv && op_s1 == fctg_pkg::OP_SAMPLE) |=> !mix.valid)
		else $error("mix item without a sample tick");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> valid_s1 && op_s1 == fctg_pkg::OP_SAMPLE && mix.valid && !mix.ready)
		else $error("input stalled without a blocked sample");

	a_noise_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		noise_q != '0)
		else $error("noise register collapsed to zero");

	a_frames_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frames_q[0] <= FW'(NOTE_FRAMES))
		else $error("frame counter above note length");

endmodule
`default_nettype wire

// ===== dv/four_channel_tone_generator_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module four_channel_tone_generator_tb;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  ch;
		logic [14:0] freq;
		logic [7:0]  vol;
		logic [1:0]  wave;
	} tone_cmd_t;

	localparam int          PER_HZ     = 22370;
	localparam logic [15:0] NOISE_POLY = 16'hB400;
	localparam logic [15:0] NOISE_SEED = 16'hACE1;
	// 40 ticks at this rate land the phase just past half a cycle
	localparam int          CREST_HZ   = 600;
	localparam int          CREST_TICKS = 41;

	localparam int QUARTER_SINE [64] = '{
		0,     804,   1608,  2410,  3212,  4011,  4808,  5602,
		6393,  7179,  7962,  8739,  9512,  10278, 11039, 11793,
		12539, 13279, 14010, 14732, 15446, 16151, 16846, 17530,
		18204, 18868, 19519, 20159, 20787, 21403, 22005, 22594,
		23170, 23731, 24279, 24811, 25329, 25832, 26319, 26790,
		27245, 27683, 28105, 28510, 28898, 29268, 29621, 29956,
		30273, 30571, 30852, 31113, 31356, 31580, 31785, 31971,
		32137, 32285, 32412, 32521, 32609, 32678, 32728, 32757
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   quiet = 1'b0;
	int   mismatches = 0;

	logic signed [15:0] expected_samples [$];

	// voice registers as the block should hold them
	logic [23:0] v_phase  [fctg_pkg::VOICES_DEF];
	logic [23:0] v_step   [fctg_pkg::VOICES_DEF];
	logic [7:0]  v_gain   [fctg_pkg::VOICES_DEF];
	logic [1:0]  v_wave   [fctg_pkg::VOICES_DEF];
	logic [7:0]  v_frames [fctg_pkg::VOICES_DEF];
	logic [15:0] noise_reg;

	fctg_cmd_if cmd_bus();
	fctg_mix_if mix_bus();

	four_channel_tone_generator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.mix    (mix_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int voice_level(int v);
		logic [23:0] p;
		int u;
		int m;
		int k;
		p = v_phase[v];
		case (v_wave[v])
			fctg_pkg::WAVE_SQUARE: return p[23] ? -32768 : 32767;
			fctg_pkg::WAVE_SINE: begin
				k = p[22] ? 64 - int'(p[21:16]) : int'(p[21:16]);
				m = (k == 64) ? 32767 : QUARTER_SINE[k];
				return p[23] ? -m : m;
			end
			fctg_pkg::WAVE_TRIANGLE: begin
				u = int'(p >> 7);
				if (!p[23]) begin
					return u - 32768;
				end
				u = 98304 - u;
				return (u > 32767) ? 32767 : u;
			end
			default: begin
				noise_reg = {1'b0, noise_reg[15:1]} ^ (noise_reg[0] ? NOISE_POLY : 16'h0000);
				return int'($signed(noise_reg));
			end
		endcase
	endfunction

	function automatic logic signed [15:0] next_mix();
		int total;
		int prod;
		int r;
		total = 0;
		for (int v = 0; v < fctg_pkg::VOICES_DEF; v++) begin
			if (v_frames[v] != 0 && v_gain[v] != 0) begin
				prod = voice_level(v) * int'(v_gain[v]);
				total += prod >>> 8;
				v_phase[v] = v_phase[v] + v_step[v];
			end
		end
		r = total >>> 2;
		if (r > 32767) begin
			r = 32767;
		end
		if (r < -32768) begin
			r = -32768;
		end
		return r[15:0];
	endfunction

	task automatic apply_item(input tone_cmd_t c);
		logic [31:0] t;
		case (c.op)
			fctg_pkg::OP_SAMPLE: expected_samples.push_back(next_mix());
			fctg_pkg::OP_PLAY: begin
				if (int'(c.ch) < fctg_pkg::VOICES_DEF) begin
					t = 32'(c.freq) * 32'(PER_HZ);
					v_step[c.ch]   = t[29:6];
					v_gain[c.ch]   = c.vol;
					v_wave[c.ch]   = c.wave;
					v_frames[c.ch] = 8'(fctg_pkg::NOTE_FRAMES_DEF);
					v_phase[c.ch]  = '0;
				end
			end
			fctg_pkg::OP_STOP: begin
				if (int'(c.ch) < fctg_pkg::VOICES_DEF) begin
					v_gain[c.ch]   = '0;
					v_frames[c.ch] = '0;
				end
			end
			default: begin
				for (int v = 0; v < fctg_pkg::VOICES_DEF; v++) begin
					if (v_frames[v] != 0) begin
						v_frames[v]--;
					end
				end
			end
		endcase
	endtask

	function automatic tone_cmd_t note_cmd(logic [1:0] op, logic [1:0] ch, int freq, int vol,
		logic [1:0] wave);
		tone_cmd_t c;
		c.op   = op;
		c.ch   = ch;
		c.freq = freq[14:0];
		c.vol  = vol[7:0];
		c.wave = wave;
		return c;
	endfunction

	function automatic int random_freq();
		case ($urandom_range(9))
			0: return 0;
			1: return 24000;
			2: return $urandom_range(1, 40);
			default: return $urandom_range(24000);
		endcase
	endfunction

	function automatic tone_cmd_t any_cmd();
		return note_cmd(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom_range(24000),
			$urandom_range(255), 2'($urandom_range(3)));
	endfunction

	task automatic send_item(input tone_cmd_t c);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 36) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid        <= 1'b1;
		cmd_bus.operation    <= c.op;
		cmd_bus.channel      <= c.ch;
		cmd_bus.frequency_hz <= c.freq;
		cmd_bus.volume       <= c.vol;
		cmd_bus.wave_kind    <= c.wave;
		@(posedge clk);
		while (!cmd_bus.ready) begin
			@(posedge clk);
		end
		apply_item(c);
	endtask

	// sender holds off until every pending sample is out
	task automatic wait_all_samples();
		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		while (expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(note_cmd(fctg_pkg::OP_SAMPLE, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
		send_item(note_cmd(fctg_pkg::OP_FRAME, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
		send_item(note_cmd(fctg_pkg::OP_STOP, 3, 0, 0, fctg_pkg::WAVE_SQUARE));
		send_item(note_cmd(fctg_pkg::OP_PLAY, 0, 24000, 255, fctg_pkg::WAVE_SQUARE));
		send_item(note_cmd(fctg_pkg::OP_PLAY, 1, 12000, 255, fctg_pkg::WAVE_SINE));
		// zero frequency: triangle parked at its minimum
		send_item(note_cmd(fctg_pkg::OP_PLAY, 2, 0, 128, fctg_pkg::WAVE_TRIANGLE));
		send_item(note_cmd(fctg_pkg::OP_PLAY, 3, 24000, 255, fctg_pkg::WAVE_NOISE));
		repeat (4) send_item(note_cmd(fctg_pkg::OP_SAMPLE, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
		// loaded but silent, phase must stay put
		send_item(note_cmd(fctg_pkg::OP_PLAY, 2, 9000, 0, fctg_pkg::WAVE_TRIANGLE));
		repeat (2) send_item(note_cmd(fctg_pkg::OP_SAMPLE, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
		send_item(note_cmd(fctg_pkg::OP_FRAME, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
		send_item(note_cmd(fctg_pkg::OP_STOP, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
		send_item(note_cmd(fctg_pkg::OP_STOP, 1, 0, 0, fctg_pkg::WAVE_SQUARE));
		send_item(note_cmd(fctg_pkg::OP_SAMPLE, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
		send_item(note_cmd(fctg_pkg::OP_PLAY, 0, 1, 1, fctg_pkg::WAVE_SQUARE));
		repeat (2) send_item(note_cmd(fctg_pkg::OP_SAMPLE, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
		for (int v = 0; v < fctg_pkg::VOICES_DEF; v++) begin
			send_item(note_cmd(fctg_pkg::OP_STOP, v[1:0], 0, 0, fctg_pkg::WAVE_SQUARE));
		end
		send_item(note_cmd(fctg_pkg::OP_SAMPLE, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
	endtask

	// triangle top half starts one count over full scale and must clip
	task automatic test_triangle_crest();
		send_item(note_cmd(fctg_pkg::OP_PLAY, 1, CREST_HZ, 255, fctg_pkg::WAVE_TRIANGLE));
		repeat (CREST_TICKS)
			send_item(note_cmd(fctg_pkg::OP_SAMPLE, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
		send_item(note_cmd(fctg_pkg::OP_STOP, 1, 0, 0, fctg_pkg::WAVE_SQUARE));
	endtask

	task automatic test_note_expiry();
		for (int v = 0; v < fctg_pkg::VOICES_DEF; v++) begin
			send_item(note_cmd(fctg_pkg::OP_PLAY, v[1:0], random_freq(),
				$urandom_range(1, 255), 2'($urandom_range(3))));
		end
		for (int f = 0; f < 64; f++) begin
			send_item(note_cmd(fctg_pkg::OP_FRAME, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
			if (f % 2 == 0 || f > 55) begin
				send_item(note_cmd(fctg_pkg::OP_SAMPLE, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
			end
			if (f == 30) begin
				send_item(note_cmd(fctg_pkg::OP_PLAY, 2, random_freq(), 255,
					fctg_pkg::WAVE_SINE));
			end
		end
	endtask

	task automatic test_random_songs(input int n_items);
		int sent;
		int notes;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					send_item(any_cmd());
					sent++;
				end
			end else begin
				notes = $urandom_range(1, 3);
				repeat (notes) begin
					send_item(note_cmd(fctg_pkg::OP_PLAY, 2'($urandom_range(3)), random_freq(),
						($urandom_range(9) == 0) ? 0 : $urandom_range(1, 255),
						2'($urandom_range(3))));
					sent++;
				end
				if ($urandom_range(4) == 0) begin
					send_item(note_cmd(fctg_pkg::OP_STOP, 2'($urandom_range(3)), 0, 0,
						fctg_pkg::WAVE_SQUARE));
					sent++;
				end
				repeat ($urandom_range(4, 20)) begin
					if ($urandom_range(4) == 0) begin
						send_item(note_cmd(fctg_pkg::OP_FRAME, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
					end else begin
						send_item(note_cmd(fctg_pkg::OP_SAMPLE, 0, 0, 0, fctg_pkg::WAVE_SQUARE));
					end
					sent++;
				end
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			mix_bus.ready <= quiet || ($urandom_range(99) >= 36);
		end
	end

	always @(posedge clk) begin
		logic signed [15:0] want;
		if (arst_n && mix_bus.valid && mix_bus.ready) begin
			if (expected_samples.size() == 0) begin
				mismatches++;
				$display("%0t: sample with none pending, expected nothing actual %0d",
					$time, mix_bus.sample);
			end else begin
				want = expected_samples.pop_front();
				if (mix_bus.sample !== want) begin
					mismatches++;
					$display("%0t: sample mismatch, expected %0d actual %0d",
						$time, want, mix_bus.sample);
				end
			end
		end
	end

	initial begin
		cmd_bus.valid        = 1'b0;
		cmd_bus.operation    = fctg_pkg::OP_SAMPLE;
		cmd_bus.channel      = '0;
		cmd_bus.frequency_hz = '0;
		cmd_bus.volume       = '0;
		cmd_bus.wave_kind    = fctg_pkg::WAVE_SQUARE;
		mix_bus.ready        = 1'b0;
		for (int v = 0; v < fctg_pkg::VOICES_DEF; v++) begin
			v_phase[v]  = '0;
			v_step[v]   = '0;
			v_gain[v]   = '0;
			v_wave[v]   = fctg_pkg::WAVE_SQUARE;
			v_frames[v] = '0;
		end
		noise_reg = NOISE_SEED;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		wait_all_samples();
		test_triangle_crest();
		wait_all_samples();
		quiet = 1'b1;
		test_note_expiry();
		wait_all_samples();
		quiet = 1'b0;
		test_random_songs(560);
		wait_all_samples();
		repeat (6) @(posedge clk);

		if (mismatches == 0) begin
			$display("four_channel_tone_generator_tb: clean");
		end else begin
			$display("four_channel_tone_generator_tb: errors");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("four_channel_tone_generator_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
